### rtl/sstod_pkg.sv
// Shared constants, register indexes and the command type for the time-of-day clock.
// No dependencies; every other file imports this package.
`default_nettype none

package sstod_pkg;

    localparam int DATA_W         = 8;
    localparam int LEN_W          = 4;
    localparam int PACKET_BYTES   = 12;
    localparam int TIME_FIRST_POS = 8;
    localparam int TIME_FIELDS    = 4;
    localparam int CFG_IDX_W      = 1;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_RX_TIMEOUT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_DIVIDE = 1'b1;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [DATA_W-1:0] RX_TIMEOUT_RST  = 8'd4;
    localparam logic [DATA_W-1:0] TICK_DIVIDE_RST = 8'd9;

    localparam logic [DATA_W-1:0] HUNDREDTH_MAX = 8'd99;
    localparam logic [DATA_W-1:0] SECOND_MAX    = 8'd59;
    localparam logic [DATA_W-1:0] MINUTE_MAX    = 8'd59;
    localparam logic [DATA_W-1:0] HOUR_MAX      = 8'd23;

    localparam int FLD_HOURS      = 0;
    localparam int FLD_MINUTES    = 1;
    localparam int FLD_SECONDS    = 2;
    localparam int FLD_HUNDREDTHS = 3;

    typedef struct packed {
        logic                                     load;
        logic [TIME_FIELDS-1:0]                   mask;
        logic [TIME_FIELDS-1:0][DATA_W-1:0]       bytes;
        logic                                     advance;
    } t_cmd;

endpackage

`default_nettype wire

### rtl/sstod_in_if.sv
// Input channel: valid/ready handshake carrying one serial byte or tick per beat.
// Depends on sstod_pkg.
`default_nettype none

interface sstod_in_if;
    import sstod_pkg::*;

    logic              valid;
    logic              ready;
    logic              op;
    logic [DATA_W-1:0] rx_byte;

    modport source (output valid, output op, output rx_byte, input ready);
    modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

`default_nettype wire

### rtl/sstod_out_if.sv
// Output channel: valid/ready handshake carrying the time and event flags per beat.
// Depends on sstod_pkg.
`default_nettype none

interface sstod_out_if;
    import sstod_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] hours;
    logic [DATA_W-1:0] minutes;
    logic [DATA_W-1:0] seconds;
    logic [DATA_W-1:0] hundredths;
    logic              time_loaded;
    logic              time_advanced;

    modport source (output valid, output hours, output minutes, output seconds,
                    output hundredths, output time_loaded, output time_advanced,
                    input ready);
    modport sink   (input valid, input hours, input minutes, input seconds,
                    input hundredths, input time_loaded, input time_advanced,
                    output ready);
endinterface

`default_nettype wire

### rtl/serial_set_time_of_day_clock.sv
// Time-of-day clock set over a serial line: top level joining front, queue and back.
// A result beat passes through the command queue and then the output register.
// Throughput: one beat per cycle when neither side stalls, set by the front and back
// each handling one beat a cycle.
// The command queue holds QUEUE_DEPTH beats so each side stalls on its own.
// Reset (synchronous, active low): time 00:00:00.00, timeout 4, divide 9, packet empty.
`default_nettype none

module serial_set_time_of_day_clock #(
    parameter int QUEUE_DEPTH = sstod_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [sstod_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [sstod_pkg::DATA_W-1:0]    i_cfg_data,
    sstod_in_if.sink                             i_in,
    sstod_out_if.source                          o_out
);
    import sstod_pkg::*;

    logic push;
    logic pop;
    logic full;
    logic empty;
    t_cmd front_cmd;
    t_cmd back_cmd;

    sstod_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_full     (full),
        .o_push     (push),
        .o_cmd      (front_cmd)
    );

    sstod_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_cmd   (back_cmd),
        .o_empty (empty)
    );

    sstod_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_cmd   (back_cmd),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

### rtl/sstod_front.sv
// Front end: accepts input beats, tracks the packet, idle and tick counters, and
// turns each beat into a load/advance command. Depends on sstod_pkg and sstod_in_if.
`default_nettype none

module sstod_front (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [sstod_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [sstod_pkg::DATA_W-1:0]     i_cfg_data,
    sstod_in_if.sink                              i_in,
    input  wire logic                             i_full,
    output logic                                  o_push,
    output sstod_pkg::t_cmd                       o_cmd
);
    import sstod_pkg::*;

    logic [DATA_W-1:0] r_rx_timeout;
    logic [DATA_W-1:0] r_tick_divide;
    logic [LEN_W-1:0]  r_len,    n_len;
    logic              r_rx,     n_rx;
    logic [DATA_W-1:0] r_idle,   n_idle;
    logic [DATA_W-1:0] r_ms,     n_ms;
    logic [TIME_FIELDS-1:0][DATA_W-1:0] r_bytes;

    logic              accept;
    logic              byte_wr;
    logic [DATA_W:0]   idle_inc;
    logic [DATA_W:0]   ms_inc;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign o_push     = accept;
    assign idle_inc   = {1'b0, r_idle} + 1'b1;
    assign ms_inc     = {1'b0, r_ms} + 1'b1;
    assign byte_wr    = accept && (i_in.op == OP_BYTE)
                        && (r_len >= LEN_W'(TIME_FIRST_POS))
                        && (r_len < LEN_W'(PACKET_BYTES));

    always_comb begin
        n_len  = r_len;
        n_rx   = r_rx;
        n_idle = r_idle;
        n_ms   = r_ms;
        o_cmd         = '0;
        o_cmd.bytes   = r_bytes;
        if (accept) begin
            if (i_in.op == OP_BYTE) begin
                if (r_len < LEN_W'(PACKET_BYTES)) begin
                    n_len = r_len + 1'b1;
                end
                n_rx   = 1'b1;
                n_idle = '0;
            end else begin
                if (r_rx) begin
                    if (idle_inc > {1'b0, r_rx_timeout}) begin
                        n_rx      = 1'b0;
                        n_idle    = '0;
                        n_len     = '0;
                        o_cmd.load = 1'b1;
                        for (int i = 0; i < TIME_FIELDS; i++) begin
                            o_cmd.mask[i] = r_len > LEN_W'(TIME_FIRST_POS + i);
                        end
                    end else begin
                        n_idle = idle_inc[DATA_W-1:0];
                    end
                end
                if (ms_inc > {1'b0, r_tick_divide}) begin
                    n_ms          = '0;
                    o_cmd.advance = 1'b1;
                end else begin
                    n_ms = ms_inc[DATA_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_timeout  <= RX_TIMEOUT_RST;
            r_tick_divide <= TICK_DIVIDE_RST;
            r_len         <= '0;
            r_rx          <= 1'b0;
            r_idle        <= '0;
            r_ms          <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_RX_TIMEOUT:  r_rx_timeout  <= i_cfg_data;
                    CFG_TICK_DIVIDE: r_tick_divide <= i_cfg_data;
                    default: ;
                endcase
            end
            r_len  <= n_len;
            r_rx   <= n_rx;
            r_idle <= n_idle;
            r_ms   <= n_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (byte_wr) begin
            r_bytes[r_len[1:0]] <= i_in.rx_byte;
        end
    end

endmodule

`default_nettype wire

### rtl/sstod_queue.sv
// Short command queue between the front and back ends.
// Depends on sstod_pkg.
`default_nettype none

module sstod_queue #(
    parameter int DEPTH = sstod_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire sstod_pkg::t_cmd i_cmd,
    output logic            o_full,
    input  wire logic       i_pop,
    output sstod_pkg::t_cmd o_cmd,
    output logic            o_empty
);
    import sstod_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("pop from empty queue");

    a_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != CNT_W'(DEPTH)) || i_pop)
        else $error("push into full queue");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count did not advance on push");

endmodule

`default_nettype wire

### rtl/sstod_back.sv
// Back end: applies load and advance commands to the time registers and holds
// the result beat. Depends on sstod_pkg and sstod_out_if.
`default_nettype none

module sstod_back (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_empty,
    input  wire sstod_pkg::t_cmd i_cmd,
    output logic            o_pop,
    sstod_out_if.source     o_out
);
    import sstod_pkg::*;

    function automatic logic [DATA_W:0] bump(input logic [DATA_W-1:0] v,
                                            input logic [DATA_W-1:0] lim);
        logic [DATA_W-1:0] inc;
        inc = v + 1'b1;
        if (inc > lim) begin
            return {1'b1, {DATA_W{1'b0}}};
        end
        return {1'b0, inc};
    endfunction

    logic [TIME_FIELDS-1:0][DATA_W-1:0] r_time, n_time;
    logic [TIME_FIELDS-1:0][DATA_W-1:0] ld_time;
    logic [DATA_W:0]                    b_hun, b_sec, b_min, b_hr;
    logic                               r_out_valid;
    logic                               r_loaded;
    logic                               r_advanced;

    assign o_pop = !i_empty && (!r_out_valid || o_out.ready);

    always_comb begin
        for (int i = 0; i < TIME_FIELDS; i++) begin
            ld_time[i] = (i_cmd.load && i_cmd.mask[i]) ? i_cmd.bytes[i] : r_time[i];
        end
        b_hun  = bump(ld_time[FLD_HUNDREDTHS], HUNDREDTH_MAX);
        b_sec  = bump(ld_time[FLD_SECONDS], SECOND_MAX);
        b_min  = bump(ld_time[FLD_MINUTES], MINUTE_MAX);
        b_hr   = bump(ld_time[FLD_HOURS], HOUR_MAX);
        n_time = ld_time;
        if (i_cmd.advance) begin
            n_time[FLD_HUNDREDTHS] = b_hun[DATA_W-1:0];
            if (b_hun[DATA_W]) begin
                n_time[FLD_SECONDS] = b_sec[DATA_W-1:0];
                if (b_sec[DATA_W]) begin
                    n_time[FLD_MINUTES] = b_min[DATA_W-1:0];
                    if (b_min[DATA_W]) begin
                        n_time[FLD_HOURS] = b_hr[DATA_W-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_time      <= n_time;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_loaded   <= i_cmd.load;
            r_advanced <= i_cmd.advance;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.hours         = r_time[FLD_HOURS];
    assign o_out.minutes       = r_time[FLD_MINUTES];
    assign o_out.seconds       = r_time[FLD_SECONDS];
    assign o_out.hundredths    = r_time[FLD_HUNDREDTHS];
    assign o_out.time_loaded   = r_loaded;
    assign o_out.time_advanced = r_advanced;

    a_pop_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_out_valid)
        else $error("popped command left no result");

    a_time_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_pop |=> $stable(r_time))
        else $error("time changed without a command");

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for serial_set_time_of_day_clock: drives byte and tick beats,
// predicts each result beat in-house and compares it field by field.
// Depends on sstod_pkg, sstod_in_if and sstod_out_if from the RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sstod_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0] hours;
        logic [DATA_W-1:0] minutes;
        logic [DATA_W-1:0] seconds;
        logic [DATA_W-1:0] hundredths;
        logic              loaded;
        logic              advanced;
    } t_tod_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [DATA_W-1:0]    i_cfg_data;

    sstod_in_if  tod_in ();
    sstod_out_if tod_out ();

    serial_set_time_of_day_clock u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (tod_in),
        .o_out      (tod_out)
    );

    always #5 i_clk = ~i_clk;

    // Clock state as the block should hold it
    logic [DATA_W-1:0] cfg_timeout = RX_TIMEOUT_RST;
    logic [DATA_W-1:0] cfg_divide  = TICK_DIVIDE_RST;
    logic [DATA_W-1:0] tod_now [TIME_FIELDS] = '{default: '0};
    logic [DATA_W-1:0] pkt_time [TIME_FIELDS] = '{default: '0};
    logic [DATA_W-1:0] field_max [TIME_FIELDS] =
        '{HOUR_MAX, MINUTE_MAX, SECOND_MAX, HUNDREDTH_MAX};
    int                pkt_len   = 0;
    logic              rx_active = 1'b0;
    logic [DATA_W-1:0] idle_cnt  = '0;
    logic [DATA_W-1:0] ms_cnt    = '0;

    t_tod_result pending_times [$];
    t_tod_result want_time;
    int          fail_count    = 0;
    int          items_sent    = 0;
    int          idle_pct      = 0;
    int          stall_pct     = 0;
    int          hold_request  = 0;
    int          hold_left     = 0;

    function automatic t_tod_result predict_time_of_day(input logic op,
                                                        input logic [DATA_W-1:0] data);
        t_tod_result r;
        int          next;
        int          i;
        logic        carry;
        r = '0;
        if (op == OP_BYTE) begin
            if (pkt_len >= TIME_FIRST_POS && pkt_len < PACKET_BYTES)
                pkt_time[pkt_len - TIME_FIRST_POS] = data;
            if (pkt_len < PACKET_BYTES)
                pkt_len++;
            rx_active = 1'b1;
            idle_cnt  = '0;
        end else begin
            if (rx_active) begin
                next = idle_cnt + 1;
                if (next > cfg_timeout) begin
                    rx_active = 1'b0;
                    idle_cnt  = '0;
                    for (i = 0; i < TIME_FIELDS; i++)
                        if (pkt_len > TIME_FIRST_POS + i)
                            tod_now[i] = pkt_time[i];
                    pkt_len  = 0;
                    r.loaded = 1'b1;
                end else begin
                    idle_cnt = next[DATA_W-1:0];
                end
            end
            next = ms_cnt + 1;
            if (next > cfg_divide) begin
                ms_cnt = '0;
                carry  = 1'b1;
                for (i = TIME_FIELDS - 1; i >= 0; i--) begin
                    if (carry) begin
                        tod_now[i] = tod_now[i] + 8'd1;
                        carry = tod_now[i] > field_max[i];
                        if (carry)
                            tod_now[i] = '0;
                    end
                end
                r.advanced = 1'b1;
            end else begin
                ms_cnt = next[DATA_W-1:0];
            end
        end
        r.hours      = tod_now[FLD_HOURS];
        r.minutes    = tod_now[FLD_MINUTES];
        r.seconds    = tod_now[FLD_SECONDS];
        r.hundredths = tod_now[FLD_HUNDREDTHS];
        return r;
    endfunction

    function automatic void check_field(string name, logic [DATA_W-1:0] expv,
                                        logic [DATA_W-1:0] actv);
        if (expv !== actv) begin
            $error("%s mismatch: expected %0d, got %0d", name, expv, actv);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && tod_out.valid && tod_out.ready) begin
            if (pending_times.size() == 0) begin
                $error("result beat with no pending input beat");
                fail_count++;
            end else begin
                want_time = pending_times.pop_front();
                check_field("hours", want_time.hours, tod_out.hours);
                check_field("minutes", want_time.minutes, tod_out.minutes);
                check_field("seconds", want_time.seconds, tod_out.seconds);
                check_field("hundredths", want_time.hundredths, tod_out.hundredths);
                check_field("time_loaded", DATA_W'(want_time.loaded),
                            DATA_W'(tod_out.time_loaded));
                check_field("time_advanced", DATA_W'(want_time.advanced),
                            DATA_W'(tod_out.time_advanced));
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            tod_out.ready <= 1'b0;
            hold_left--;
        end else begin
            tod_out.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic send_beat(input logic op, input logic [DATA_W-1:0] data);
        while ($urandom_range(0, 99) < idle_pct) begin
            tod_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        tod_in.valid   <= 1'b1;
        tod_in.op      <= op;
        tod_in.rx_byte <= data;
        do @(posedge i_clk); while (!tod_in.ready);
        pending_times.push_back(predict_time_of_day(op, data));
        items_sent++;
    endtask

    task automatic wait_results_drained();
        tod_in.valid <= 1'b0;
        while (pending_times.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [DATA_W-1:0] timeout,
                              input logic [DATA_W-1:0] divide);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_RX_TIMEOUT;
        i_cfg_data <= timeout;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_TICK_DIVIDE;
        i_cfg_data <= divide;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_timeout = timeout;
        cfg_divide  = divide;
    endtask

    task automatic test_reset_tick();
        send_beat(OP_TICK, 8'h00);
        send_beat(OP_TICK, 8'hFF);
        wait_results_drained();
    endtask

    // Load 23:59:59.99 and roll over on the same tick; one byte past the packet end
    task automatic test_carry_chain();
        int i;
        set_config(8'd1, 8'd0);
        for (i = 0; i < TIME_FIRST_POS; i++)
            send_beat(OP_BYTE, 8'h00);
        send_beat(OP_BYTE, HOUR_MAX);
        send_beat(OP_BYTE, MINUTE_MAX);
        send_beat(OP_BYTE, SECOND_MAX);
        send_beat(OP_BYTE, HUNDREDTH_MAX);
        send_beat(OP_BYTE, 8'hA5);
        send_beat(OP_TICK, 8'h00);
        send_beat(OP_TICK, 8'hFF);
        wait_results_drained();
    endtask

    task automatic test_out_of_range_load();
        int i;
        for (i = 0; i < PACKET_BYTES; i++)
            send_beat(OP_BYTE, 8'hFF);
        send_beat(OP_TICK, 8'h5A);
        send_beat(OP_TICK, 8'h00);
        wait_results_drained();
    endtask

    // Hold off the receiver while beats keep coming, then pause until all results are in
    task automatic test_backpressure();
        idle_pct     = 0;
        stall_pct    = 0;
        hold_request = 50;
        repeat (30)
            send_beat(1'($urandom_range(0, 1)), DATA_W'($urandom_range(0, 255)));
        wait_results_drained();
    endtask

    task automatic test_random_traffic(input logic [DATA_W-1:0] timeout,
                                       input logic [DATA_W-1:0] divide,
                                       input int sender_idle, input int receiver_stall,
                                       input int count);
        int                target;
        int                len;
        int                i;
        int                field;
        int                ticks;
        logic [DATA_W-1:0] data;
        set_config(timeout, divide);
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
        target    = items_sent + count;
        while (items_sent < target) begin
            if ($urandom_range(0, 99) < 80) begin
                len = ($urandom_range(0, 99) < 60) ? PACKET_BYTES
                                                   : $urandom_range(1, PACKET_BYTES + 3);
                for (i = 0; i < len; i++) begin
                    field = i - TIME_FIRST_POS;
                    if (field >= 0 && field < TIME_FIELDS) begin
                        case ($urandom_range(0, 5))
                            0: data = '0;
                            1: data = field_max[field];
                            2: data = field_max[field] + 8'd1;
                            3: data = 8'hFF;
                            4: data = DATA_W'($urandom_range(0, field_max[field]));
                            default: data = DATA_W'($urandom_range(0, 255));
                        endcase
                    end else begin
                        data = DATA_W'($urandom_range(0, 255));
                    end
                    send_beat(OP_BYTE, data);
                end
                ticks = $urandom_range(0, cfg_timeout + 2);
                repeat (ticks)
                    send_beat(OP_TICK, DATA_W'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 4))
                    send_beat(1'($urandom_range(0, 1)), DATA_W'($urandom_range(0, 255)));
            end
        end
        wait_results_drained();
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= CFG_RX_TIMEOUT;
        i_cfg_data     <= '0;
        tod_in.valid   <= 1'b0;
        tod_in.op      <= OP_BYTE;
        tod_in.rx_byte <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_tick();
        test_carry_chain();
        test_out_of_range_load();
        test_backpressure();
        test_random_traffic(8'd1, 8'd0, 0, 0, 180);
        test_random_traffic(8'd3, 8'd2, 45, 0, 170);
        test_random_traffic(8'd2, 8'd1, 0, 45, 170);
        test_random_traffic(8'd6, 8'd4, 26, 26, 150);
        test_random_traffic(8'd255, 8'd255, 26, 26, 300);
        test_backpressure();

        if (fail_count == 0 && pending_times.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
